### design/rmxpt_pkg.sv
// Shared codes and controller/datapath interface types for the range max-xor trie.
package rmxpt_pkg;

	localparam int BOUND_W = 13;

	localparam logic MODE_APPEND = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_RANGE = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef struct packed {
		logic latch;
		logic setup;
		logic fetch;
		logic ap_step;
		logic q_step;
		logic leaf;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic is_query;
		logic reject;
		logic last_level;
		logic out_free;
	} dp_stat_t;

endpackage

### design/range_max_xor_persistent_trie_top.sv
// Top level of the range max-xor block over a persistent binary trie.
// Append: the next beat can be accepted once the append walk has returned to idle; no result.
// Query: the result is loaded after decode, node fetch, the trie walk and the leaf read,
// once the output register is free to take it.
// A rejected beat (bad range or full store) goes from decode straight to the result load.
// One beat is in work at a time; the walk reads one trie level per cycle from node memory.
// Reset (arst_n low) empties the sequence at once; no memory clearing pass is needed.
module range_max_xor_persistent_trie_top #(
	parameter int VALUE_BITS = 24,
	parameter int MAX_ITEMS  = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic [VALUE_BITS-1:0]         value,
	input  logic [rmxpt_pkg::BOUND_W-1:0] left_bound,
	input  logic [rmxpt_pkg::BOUND_W-1:0] right_bound,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [VALUE_BITS-1:0]         max_xor,
	output logic [1:0]                    status
);

	// The controller only issues commands; all storage lives in the datapath.
	// Each node word carries both children and the newest prefix index under
	// each child, so a query decides a level from a single memory read.
	rmxpt_pkg::dp_cmd_t  cmd;
	rmxpt_pkg::dp_stat_t stat;

	rmxpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rmxpt_dp #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_ITEMS  (MAX_ITEMS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.mode        (mode),
		.value       (value),
		.left_bound  (left_bound),
		.right_bound (right_bound),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.max_xor     (max_xor),
		.status      (status)
	);

endmodule

### design/rmxpt_dp.sv
// Datapath: node and prefix memories, trie walk registers and result register.
module rmxpt_dp #(
	parameter int VALUE_BITS = 24,
	parameter int MAX_ITEMS  = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rmxpt_pkg::dp_cmd_t              cmd,
	output rmxpt_pkg::dp_stat_t             stat,
	input  logic                            mode,
	input  logic [VALUE_BITS-1:0]           value,
	input  logic [rmxpt_pkg::BOUND_W-1:0]   left_bound,
	input  logic [rmxpt_pkg::BOUND_W-1:0]   right_bound,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [VALUE_BITS-1:0]           max_xor,
	output logic [1:0]                      status
);

	localparam int IDX_W   = $clog2(MAX_ITEMS + 1);
	localparam int NODES   = 1 + (MAX_ITEMS + 1) * (VALUE_BITS + 1);
	localparam int NODE_W  = $clog2(NODES);
	localparam int LVL_W   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam int CW      = (IDX_W > rmxpt_pkg::BOUND_W) ? IDX_W : rmxpt_pkg::BOUND_W;
	localparam int WORD_W  = 2 * (NODE_W + IDX_W);
	localparam logic [NODE_W-1:0] LVL_NODES = NODE_W'(VALUE_BITS + 1);

	// Latched input beat.
	logic                          mode_q;
	logic [VALUE_BITS-1:0]         val_q;
	logic [rmxpt_pkg::BOUND_W-1:0] l_q, r_q;

	// Sequence state.
	logic [IDX_W-1:0]      item_cnt_q;
	logic [VALUE_BITS-1:0] total_q;
	logic [NODE_W-1:0]     root_last_q;

	// Walk registers.
	logic [NODE_W-1:0]     node_q, cur_q;
	logic [IDX_W-1:0]      n_q, leaf_q;
	logic [VALUE_BITS-1:0] key_q;
	logic [CW-1:0]         limit_q;
	logic [LVL_W-1:0]      lvl_q;
	logic                  res_err_q;
	rmxpt_pkg::status_t    res_st_q;
	logic [VALUE_BITS-1:0] pdata_q;
	logic                  pzero_q;

	// Output register.
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] max_xor_q;
	rmxpt_pkg::status_t    status_q;

	// Node word: {newest1, child1, newest0, child0}; newest is meaningful for a nonzero child.
	logic [WORD_W-1:0]     node_mem [NODES];
	logic [VALUE_BITS-1:0] pfx_mem [MAX_ITEMS + 1];
	logic [WORD_W-1:0]     word_q;
	logic [NODE_W-1:0]     raddr_q;

	logic [CW-1:0]         l_ext, r_ext, cnt_ext;
	logic                  bad, full, reject;
	logic [IDX_W-1:0]      n_next;
	logic [VALUE_BITS-1:0] key_next;
	logic [NODE_W-1:0]     q_root;
	logic                  virt;
	logic [WORD_W-1:0]     vword, rd_word, wr_word;
	logic [NODE_W-1:0]     rd_c0, rd_c1, next_ap, other_c, same_c, nxt_c, rd_addr;
	logic [IDX_W-1:0]      rd_n0, rd_n1, other_n, same_n, nxt_n;
	logic                  kbit, take, rd_en;
	logic [VALUE_BITS-1:0] res_val;

	always_comb begin
		l_ext    = CW'(l_q);
		r_ext    = CW'(r_q);
		cnt_ext  = CW'(item_cnt_q);
		bad      = (l_q == '0) || (r_q == '0) || (l_ext > r_ext) || (r_ext > cnt_ext);
		full     = (item_cnt_q >= IDX_W'(MAX_ITEMS));
		reject   = (mode_q == rmxpt_pkg::MODE_QUERY) ? bad : full;
		n_next   = item_cnt_q + IDX_W'(1);
		key_next = total_q ^ val_q;
		q_root   = NODE_W'(1) + NODE_W'(r_ext - CW'(1)) * LVL_NODES;
	end

	// Node zero and the prefix-zero path exist from reset without being written.
	always_comb begin
		virt = (raddr_q <= NODE_W'(VALUE_BITS));
		if (raddr_q == '0) begin
			vword = '0;
		end else begin
			vword = {IDX_W'(0), NODE_W'(0), IDX_W'(0), raddr_q + NODE_W'(1)};
		end
		rd_word = virt ? vword : word_q;
		rd_c0   = rd_word[NODE_W-1:0];
		rd_n0   = rd_word[NODE_W+IDX_W-1:NODE_W];
		rd_c1   = rd_word[2*NODE_W+IDX_W-1:NODE_W+IDX_W];
		rd_n1   = rd_word[WORD_W-1:2*NODE_W+IDX_W];
		kbit    = key_q[lvl_q];

		next_ap = kbit ? rd_c1 : rd_c0;
		if (kbit) begin
			wr_word = {n_q, cur_q + NODE_W'(1), rd_n0, rd_c0};
		end else begin
			wr_word = {rd_n1, rd_c1, n_q, cur_q + NODE_W'(1)};
		end

		other_c = kbit ? rd_c0 : rd_c1;
		other_n = kbit ? rd_n0 : rd_n1;
		same_c  = kbit ? rd_c1 : rd_c0;
		same_n  = kbit ? rd_n1 : rd_n0;
		take    = (other_c != '0) && (CW'(other_n) >= limit_q);
		nxt_c   = take ? other_c : same_c;
		nxt_n   = take ? other_n : same_n;

		rd_en   = cmd.fetch || cmd.ap_step || cmd.q_step;
		if (cmd.ap_step) begin
			rd_addr = next_ap;
		end else if (cmd.q_step) begin
			rd_addr = nxt_c;
		end else begin
			rd_addr = node_q;
		end

		res_val = res_err_q ? '0 : (key_q ^ (pzero_q ? '0 : pdata_q));
	end

	always_ff @(posedge clk) begin
		if (cmd.ap_step) begin
			node_mem[cur_q] <= wr_word;
		end
		if (rd_en) begin
			word_q  <= node_mem[rd_addr];
			raddr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup && (mode_q == rmxpt_pkg::MODE_APPEND) && !reject) begin
			pfx_mem[n_next] <= key_next;
		end
		if (cmd.leaf) begin
			pdata_q <= pfx_mem[leaf_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_cnt_q  <= '0;
			total_q     <= '0;
			root_last_q <= NODE_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.setup && (mode_q == rmxpt_pkg::MODE_APPEND) && !reject) begin
				item_cnt_q  <= n_next;
				total_q     <= key_next;
				root_last_q <= root_last_q + LVL_NODES;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q <= mode;
			val_q  <= value;
			l_q    <= left_bound;
			r_q    <= right_bound;
		end
		if (cmd.setup) begin
			lvl_q     <= LVL_W'(VALUE_BITS - 1);
			res_err_q <= reject;
			key_q     <= key_next;
			n_q       <= n_next;
			limit_q   <= l_ext - CW'(1);
			if (!reject) begin
				res_st_q <= rmxpt_pkg::ST_OK;
			end else if (mode_q == rmxpt_pkg::MODE_QUERY) begin
				res_st_q <= rmxpt_pkg::ST_BAD_RANGE;
			end else begin
				res_st_q <= rmxpt_pkg::ST_FULL;
			end
			if (mode_q == rmxpt_pkg::MODE_QUERY) begin
				node_q <= q_root;
			end else begin
				node_q <= root_last_q;
				cur_q  <= root_last_q + LVL_NODES;
			end
		end
		if (cmd.ap_step) begin
			cur_q <= cur_q + NODE_W'(1);
			lvl_q <= lvl_q - LVL_W'(1);
		end
		if (cmd.q_step) begin
			lvl_q <= lvl_q - LVL_W'(1);
			if (lvl_q == '0) begin
				leaf_q <= (nxt_c != '0) ? nxt_n : '0;
			end
		end
		if (cmd.leaf) begin
			pzero_q <= (leaf_q == '0);
		end
		if (cmd.load_out) begin
			max_xor_q <= res_val;
			status_q  <= res_st_q;
		end
	end

	always_comb begin
		stat.is_query   = (mode_q == rmxpt_pkg::MODE_QUERY);
		stat.reject     = reject;
		stat.last_level = (lvl_q == '0);
		stat.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign max_xor   = max_xor_q;
	assign status    = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		item_cnt_q <= IDX_W'(MAX_ITEMS))
		else $error("item count passed capacity");

	a_no_self_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ap_step |-> (next_ap != cur_q))
		else $error("append walk reads the node it writes");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result overwrote an untaken beat");

	a_append_nodes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ap_step |-> (cur_q > NODE_W'(VALUE_BITS)))
		else $error("append wrote into the reset trie");

endmodule

### design/rmxpt_ctrl.sv
// Controller: sequences decode, node fetch, trie walk, leaf read and result load.
module rmxpt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rmxpt_pkg::dp_stat_t  stat,
	output rmxpt_pkg::dp_cmd_t   cmd
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_DECODE  = 7'b0000010,
		S_FETCH   = 7'b0000100,
		S_AP_WALK = 7'b0001000,
		S_Q_WALK  = 7'b0010000,
		S_LEAF    = 7'b0100000,
		S_RESP    = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.setup = 1'b1;
				state_d   = stat.reject ? S_RESP : S_FETCH;
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = stat.is_query ? S_Q_WALK : S_AP_WALK;
			end
			S_AP_WALK: begin
				cmd.ap_step = 1'b1;
				if (stat.last_level) begin
					state_d = S_IDLE;
				end
			end
			S_Q_WALK: begin
				cmd.q_step = 1'b1;
				if (stat.last_level) begin
					state_d = S_LEAF;
				end
			end
			S_LEAF: begin
				cmd.leaf = 1'b1;
				state_d  = S_RESP;
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	a_walk_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_Q_WALK && stat.last_level) |=> (state_q == S_LEAF))
		else $error("query walk did not end in leaf read");

	a_decode_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DECODE))
		else $error("accepted beat not decoded");

	a_leaf_to_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LEAF) |=> (state_q == S_RESP))
		else $error("leaf read not followed by response");

endmodule
